/* rtl/core/reqb_pkg.sv */
// ----------------------------------------------------------------------------
// reqb_pkg: shared types and constants
// Opcodes, register indexes, reset values and the switch qualifier
// interface types used by the rotary encoder and button qualifier.
// ----------------------------------------------------------------------------
package reqb_pkg;

	localparam int OP_W    = 3;
	localparam int REG_W   = 8;
	localparam int IDX_W   = 2;
	localparam int FTURN_W = 8;
	localparam int TURN_W  = 9;

	typedef enum logic [OP_W-1:0] {
		OP_TICK        = 3'd0,
		OP_READ        = 3'd1,
		OP_READ_NORM   = 3'd2,
		OP_FORCE_CLICK = 3'd3,
		OP_FORCE_TURNS = 3'd4
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_SAMPLE_INTERVAL = 2'd0,
		REG_RELEASE_HOLDOFF = 2'd1,
		REG_MIN_PRESS       = 2'd2
	} reg_idx_t;

	localparam logic [REG_W-1:0] SAMPLE_INTERVAL_RST = 8'd2;
	localparam logic [REG_W-1:0] RELEASE_HOLDOFF_RST = 8'd100;
	localparam logic [REG_W-1:0] MIN_PRESS_RST       = 8'd20;
	localparam logic [REG_W-1:0] MS_MAX              = 8'd255;

	// One millisecond step for the switch qualifier.
	typedef struct packed {
		logic tick;
		logic released;
	} sw_cmd_t;

	typedef struct packed {
		logic [REG_W-1:0] release_holdoff;
		logic [REG_W-1:0] min_press;
	} sw_cfg_t;

	function automatic logic [REG_W-1:0] sat_inc(input logic [REG_W-1:0] v);
		sat_inc = (v == MS_MAX) ? v : v + REG_W'(1);
	endfunction

endpackage

/* rtl/core/reqb_in_if.sv */
// ----------------------------------------------------------------------------
// reqb_in_if: input item channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface reqb_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        opcode;
	logic              line_a;
	logic              line_b;
	logic              switch_level;
	logic              force_click_value;
	logic signed [7:0] force_turn_value;

	modport source (
		output valid, opcode, line_a, line_b, switch_level,
		       force_click_value, force_turn_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, line_a, line_b, switch_level,
		       force_click_value, force_turn_value,
		output ready
	);
endinterface

/* rtl/core/reqb_out_if.sv */
// ----------------------------------------------------------------------------
// reqb_out_if: result channel
// Valid/ready channel carrying one read result.
// ----------------------------------------------------------------------------
interface reqb_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] turn_total;
	logic              click_count;

	modport source (
		output valid, turn_total, click_count,
		input  ready
	);
	modport sink (
		input  valid, turn_total, click_count,
		output ready
	);
endinterface

/* rtl/core/reqb_switch.sv */
// ----------------------------------------------------------------------------
// reqb_switch: push switch click qualifier
// Times presses of the active-low switch and flags a click on a qualified
// release, with a holdoff between release checks.
// ----------------------------------------------------------------------------
module reqb_switch (
	input  logic              clk,
	input  logic              arst_n,
	input  reqb_pkg::sw_cmd_t cmd,
	input  reqb_pkg::sw_cfg_t cfg,
	output logic              click
);
	import reqb_pkg::*;

	logic             press_active_q;
	logic [REG_W-1:0] press_ms_q;
	logic [REG_W-1:0] since_check_q;

	logic             press_active_d;
	logic [REG_W-1:0] press_ms_d;
	logic [REG_W-1:0] since_check_d;
	logic [REG_W-1:0] press_ms_inc;
	logic [REG_W-1:0] since_check_inc;

	always_comb begin
		press_ms_inc    = press_active_q ? sat_inc(press_ms_q) : press_ms_q;
		since_check_inc = sat_inc(since_check_q);
		press_active_d  = press_active_q;
		press_ms_d      = press_ms_q;
		since_check_d   = since_check_q;
		click           = 1'b0;
		if (cmd.tick) begin
			press_ms_d    = press_ms_inc;
			since_check_d = since_check_inc;
			if (!cmd.released) begin
				if (!press_active_q) begin
					press_active_d = 1'b1;
					press_ms_d     = '0;
				end
			end else if (since_check_inc > cfg.release_holdoff) begin
				since_check_d = '0;
				if (press_active_q && press_ms_inc >= cfg.min_press) begin
					click          = 1'b1;
					press_active_d = 1'b0;
					press_ms_d     = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_active_q <= 1'b0;
			press_ms_q     <= '0;
			since_check_q  <= '0;
		end else begin
			press_active_q <= press_active_d;
			press_ms_q     <= press_ms_d;
			since_check_q  <= since_check_d;
		end
	end

endmodule

/* rtl/core/rotary_encoder_button_qualifier_unit.sv */
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier_unit: encoder decoder and click qualifier
// Decodes a quadrature encoder sampled on millisecond ticks and qualifies
// clicks of an active-low push switch; reads return turns and click.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the "item" channel; each transfer carries an opcode. A tick
// stands for one millisecond and carries the encoder lines and the switch
// level. A read or normalized read produces exactly one transfer on the
// "result" channel; ticks and force items produce none.
// An accepted item lands in the input stage register and is executed from
// there; a read result passes through the input stage and then the result
// register before it is presented on the result channel. One item is taken
// per cycle while the item channel asserts ready; the input stage and the
// result register form a two-deep path, so a full result register does not
// block ticks or forces, and a read waits in the input stage only while the
// previous result is unclaimed.
// While the receiver stalls with a result held and a read waiting, the
// item channel deasserts ready. Configuration writes through cfg_wr_en,
// cfg_index and cfg_data take effect on the next clock edge; writes to an
// unused index are ignored. Reset clears all counters, sums and flags and
// loads the register reset values (interval 2, holdoff 100, min press 20).
// ----------------------------------------------------------------------------
module rotary_encoder_button_qualifier_unit #(
	parameter int SAMPLES_PER_READ = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	reqb_in_if.sink                      item,
	reqb_out_if.source                   result,
	input  logic                         cfg_wr_en,
	input  logic [reqb_pkg::IDX_W-1:0]   cfg_index,
	input  logic [reqb_pkg::REG_W-1:0]   cfg_data
);
	import reqb_pkg::*;

	// Sample counter must hold SAMPLES_PER_READ itself. The turn sum never
	// exceeds half the per-read sample limit, rounded up, in magnitude.
	localparam int CNT_W     = $clog2(SAMPLES_PER_READ + 1);
	localparam int SUM_MAX   = (SAMPLES_PER_READ + 1) / 2;
	localparam int TSUM_W    = $clog2(SUM_MAX + 1) + 1;

	// Configuration registers.
	logic [REG_W-1:0] sample_interval_q;
	logic [REG_W-1:0] release_holdoff_q;
	logic [REG_W-1:0] min_press_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_interval_q <= SAMPLE_INTERVAL_RST;
			release_holdoff_q <= RELEASE_HOLDOFF_RST;
			min_press_q       <= MIN_PRESS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data;
				REG_RELEASE_HOLDOFF: release_holdoff_q <= cfg_data;
				REG_MIN_PRESS:       min_press_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage register. The payload is captured on every transfer.
	logic                     valid_s1;
	logic [OP_W-1:0]          opcode_s1;
	logic                     line_a_s1;
	logic                     line_b_s1;
	logic                     switch_level_s1;
	logic                     force_click_s1;
	logic signed [FTURN_W-1:0] force_turn_s1;

	logic is_tick, is_read, is_norm, is_fclick, is_fturn;
	logic out_free;
	logic advance;

	always_comb begin
		is_tick   = 1'b0;
		is_read   = 1'b0;
		is_norm   = 1'b0;
		is_fclick = 1'b0;
		is_fturn  = 1'b0;
		case (opcode_s1)
			OP_TICK:        is_tick   = 1'b1;
			OP_READ:        is_read   = 1'b1;
			OP_READ_NORM: begin
				is_read = 1'b1;
				is_norm = 1'b1;
			end
			OP_FORCE_CLICK: is_fclick = 1'b1;
			OP_FORCE_TURNS: is_fturn  = 1'b1;
			default: ;
		endcase
	end

	// A read only moves on when the result register is empty or being drained;
	// every other kind of item executes immediately.
	assign out_free   = !result.valid || result.ready;
	assign advance    = valid_s1 && (!is_read || out_free);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1       <= item.opcode;
			line_a_s1       <= item.line_a;
			line_b_s1       <= item.line_b;
			switch_level_s1 <= item.switch_level;
			force_click_s1  <= item.force_click_value;
			force_turn_s1   <= item.force_turn_value;
		end
	end

	// Encoder sampling and turn accumulation.
	logic [REG_W-1:0]         since_sample_q;
	logic [CNT_W-1:0]         sample_count_q;
	logic signed [TSUM_W-1:0] turn_sum_q;
	logic                     armed_q;
	logic                     pending_click_q;
	logic signed [FTURN_W-1:0] forced_turns_q;

	logic                     do_tick;
	logic                     do_read;
	logic [REG_W-1:0]         since_sample_inc;
	logic                     sample_due;
	logic                     sample_take;
	logic                     click_set;

	assign do_tick          = advance && is_tick;
	assign do_read          = advance && is_read;
	assign since_sample_inc = sat_inc(since_sample_q);
	assign sample_due       = since_sample_inc >= sample_interval_q;
	assign sample_take      = do_tick && sample_due &&
	                          (sample_count_q < CNT_W'(SAMPLES_PER_READ));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_sample_q <= '0;
			sample_count_q <= '0;
			turn_sum_q     <= '0;
			armed_q        <= 1'b0;
		end else begin
			if (do_tick) begin
				since_sample_q <= sample_due ? '0 : since_sample_inc;
			end
			if (do_read) begin
				sample_count_q <= '0;
				turn_sum_q     <= '0;
			end else if (sample_take) begin
				sample_count_q <= sample_count_q + CNT_W'(1);
				// A count happens when the lines leave the both-high state;
				// line A still high means a positive step.
				if (line_a_s1 && line_b_s1) begin
					armed_q <= 1'b1;
				end else if (armed_q) begin
					armed_q    <= 1'b0;
					turn_sum_q <= turn_sum_q +
					              (line_a_s1 ? TSUM_W'(1) : {TSUM_W{1'b1}});
				end
			end
		end
	end

	// Switch qualifier.
	sw_cmd_t sw_cmd;
	sw_cfg_t sw_cfg;

	assign sw_cmd.tick            = do_tick;
	assign sw_cmd.released        = switch_level_s1;
	assign sw_cfg.release_holdoff = release_holdoff_q;
	assign sw_cfg.min_press       = min_press_q;

	reqb_switch u_switch (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (sw_cmd),
		.cfg    (sw_cfg),
		.click  (click_set)
	);

	// Pending click and forced turns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_click_q <= 1'b0;
			forced_turns_q  <= '0;
		end else if (advance) begin
			if (is_read) begin
				pending_click_q <= 1'b0;
				forced_turns_q  <= '0;
			end else if (is_fclick) begin
				pending_click_q <= force_click_s1;
			end else if (is_fturn) begin
				forced_turns_q <= force_turn_s1;
			end else if (click_set) begin
				pending_click_q <= 1'b1;
			end
		end
	end

	// Read result: the sum of both turn sources, or just its sign.
	logic signed [TURN_W-1:0] total;
	logic signed [TURN_W-1:0] total_out;

	always_comb begin
		total = {{(TURN_W-TSUM_W){turn_sum_q[TSUM_W-1]}}, turn_sum_q} +
		        {{(TURN_W-FTURN_W){forced_turns_q[FTURN_W-1]}}, forced_turns_q};
		total_out = total;
		if (is_norm) begin
			if (total[TURN_W-1]) begin
				total_out = {TURN_W{1'b1}};
			end else if (total != '0) begin
				total_out = TURN_W'(1);
			end else begin
				total_out = '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (do_read) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read) begin
			result.turn_total  <= total_out;
			result.click_count <= pending_click_q;
		end
	end

	// Assertions.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sample_count_q) <= SAMPLES_PER_READ)
		else $error("sample count above per-read limit");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(turn_sum_q) <= SUM_MAX) && (int'(turn_sum_q) >= -SUM_MAX))
		else $error("turn sum out of range");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> result.valid)
		else $error("read did not produce a result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && is_read && result.valid && !result.ready))
		else $error("item channel stalled without a blocked read");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_read |=> (sample_count_q == '0) && !pending_click_q)
		else $error("read did not clear accumulated state");

endmodule
